/* src/vpj_pkg.sv */
`default_nettype none
package vpj_pkg;
  localparam int MAX_SCALE = 38;
  localparam int NDIG = 39;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;
  localparam logic [1:0] ST_SCALE = 2'd3;

  typedef struct packed {
    logic [5:0]  type_id;
    logic [7:0]  byte_count;
    logic [7:0]  decimal_scale;
    logic [63:0] payload_low;
    logic [63:0] payload_high;
  } in_word_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
    logic [1:0] status;
  } out_word_t;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    hex_char = (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h57 + {4'd0, n});
  endfunction
endpackage
`default_nettype wire

/* src/vpj_if.sv */
`default_nettype none
interface vpj_in_if;
  import vpj_pkg::*;
  logic valid;
  logic ready;
  in_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface vpj_out_if;
  import vpj_pkg::*;
  logic valid;
  logic ready;
  out_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/vpj_dabble.sv */
`default_nettype none
// Bit-serial binary to BCD (double dabble): one magnitude bit per cycle.
module vpj_dabble (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [127:0] mag,
  output logic              done,
  output logic [155:0]      bcd
);
  import vpj_pkg::*;
  logic [127:0] sh;
  logic [7:0]   cnt;
  logic         busy;
  logic [155:0] adj;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= 8'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 8'd0;
      sh <= mag;
      bcd <= '0;
    end else if (busy) begin
      bcd <= {adj[154:0], sh[127]};
      sh <= {sh[126:0], 1'b0};
      cnt <= cnt + 8'd1;
      if (cnt == 8'd127) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

/* src/variant_primitive_to_json_text.sv */
// Numbers go through bit-serial conversion first, then one character per
// cycle while out_ch.ready is high; uuid, literals and errors go straight to output.
// One word at a time: input is ready only in idle, and the 128-step double
// dabble loop holds off the next word while a number converts.
// Reset: synchronous rst clears control state; output invalid, input ready.
`default_nettype none
module variant_primitive_to_json_text (
  input wire logic  clk,
  input wire logic  rst,
  vpj_in_if.sink    in_ch,
  vpj_out_if.source out_ch
);
  import vpj_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_EMIT = 3'd2;
  localparam logic [2:0] S_ERR  = 3'd3;

  localparam logic [1:0] K_NUM = 2'd0;
  localparam logic [1:0] K_UUID = 2'd1;
  localparam logic [1:0] K_TXT = 2'd2;

  logic [2:0]   state;
  logic [1:0]   kind;
  logic [1:0]   err_code;
  logic         neg;
  logic [7:0]   scale;
  logic [5:0]   ndig;
  logic [5:0]   pos;      // character index
  logic [5:0]   total;    // total characters
  logic [39:0]  txt;      // literal text, first char high
  logic [127:0] raw;      // uuid bytes
  logic [127:0] mag_in;
  logic         start;
  logic         done;
  logic [155:0] bcd;

  vpj_dabble u_dab (.clk, .rst, .start, .mag(mag_in), .done, .bcd);

  // decode of incoming word
  in_word_t   w;
  logic [4:0] width;
  logic       is_num, is_dec;
  logic [127:0] sx;
  logic       sneg;
  assign w = in_ch.data;

  always_comb begin
    width = 5'd8; is_num = 1'b0; is_dec = 1'b0;
    case (w.type_id)
      6'd3: begin width = 5'd1; is_num = 1'b1; end
      6'd4: begin width = 5'd2; is_num = 1'b1; end
      6'd5, 6'd11: begin width = 5'd4; is_num = 1'b1; end
      6'd6, 6'd12, 6'd13, 6'd17, 6'd18, 6'd19: begin width = 5'd8; is_num = 1'b1; end
      6'd8: begin width = 5'd4; is_dec = 1'b1; end
      6'd9: begin width = 5'd8; is_dec = 1'b1; end
      6'd10: begin width = 5'd16; is_dec = 1'b1; end
      default: ;
    endcase
    case (width)
      5'd1: sx = {{120{w.payload_low[7]}}, w.payload_low[7:0]};
      5'd2: sx = {{112{w.payload_low[15]}}, w.payload_low[15:0]};
      5'd4: sx = {{96{w.payload_low[31]}}, w.payload_low[31:0]};
      5'd8: sx = {{64{w.payload_low[63]}}, w.payload_low};
      default: sx = {w.payload_high, w.payload_low};
    endcase
    sneg = sx[127];
  end

  // digit count from BCD: index of highest non-zero digit plus one, min 1
  logic [5:0] nd_c;
  always_comb begin
    nd_c = 6'd1;
    for (int i = 1; i < NDIG; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) nd_c = 6'(i + 1);
    end
  end

  // character at pos for numbers
  logic [7:0] num_c, uuid_c, txt_c, cur_c;
  logic [5:0] p, lead, di;
  logic [7:0] nd8;
  always_comb begin
    p = pos - {5'd0, neg};
    nd8 = {2'd0, ndig};
    num_c = 8'h30;
    di = 6'd0;
    if (neg && pos == 6'd0) begin
      num_c = 8'h2d;
    end else if (scale == 8'd0) begin
      di = ndig - 6'd1 - p;
      num_c = 8'h30 + {4'd0, bcd[di*4 +: 4]};
    end else if (scale >= nd8) begin
      lead = 6'(scale) - ndig;
      if (p == 6'd0) num_c = 8'h30;
      else if (p == 6'd1) num_c = 8'h2e;
      else if (p < lead + 6'd2) num_c = 8'h30;
      else begin
        di = ndig - 6'd1 - (p - lead - 6'd2);
        num_c = 8'h30 + {4'd0, bcd[di*4 +: 4]};
      end
    end else begin
      lead = ndig - 6'(scale);
      if (p == lead) num_c = 8'h2e;
      else begin
        di = (p < lead) ? ndig - 6'd1 - p : ndig - p;
        num_c = 8'h30 + {4'd0, bcd[di*4 +: 4]};
      end
    end
    lead = 6'd0;
  end

  logic [5:0] uq, uh;
  logic [7:0] ub;
  always_comb begin
    uq = pos - 6'd1;
    if (pos > 6'd9) uq = uq - 6'd1;
    if (pos > 6'd14) uq = uq - 6'd1;
    if (pos > 6'd19) uq = uq - 6'd1;
    if (pos > 6'd24) uq = uq - 6'd1;
    uh = {1'b0, uq[5:1]};
    ub = raw[uh[3:0]*8 +: 8];
    if (pos == 6'd0 || pos == 6'd37) uuid_c = 8'h22;
    else if (pos == 6'd9 || pos == 6'd14 || pos == 6'd19 || pos == 6'd24) uuid_c = 8'h2d;
    else uuid_c = hex_char(uq[0] ? ub[3:0] : ub[7:4]);
    txt_c = txt[39 - 8*pos[2:0] -: 8];
    case (kind)
      K_NUM: cur_c = num_c;
      K_UUID: cur_c = uuid_c;
      default: cur_c = txt_c;
    endcase
  end

  logic [5:0] ntot;
  always_comb begin
    if (scale == 8'd0) ntot = nd_c;
    else if (scale >= {2'd0, nd_c}) ntot = 6'(scale) + 6'd2;
    else ntot = nd_c + 6'd1;
    ntot = ntot + {5'd0, neg};
  end

  assign in_ch.ready = (state == S_IDLE);
  assign start = in_ch.valid && in_ch.ready && (is_num || is_dec) &&
                 !(w.byte_count < {3'd0, width} + {7'd0, is_dec}) &&
                 !(is_dec && w.decimal_scale > 8'(MAX_SCALE));
  assign mag_in = sneg ? (~sx + 128'd1) : sx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pos <= 6'd0;
    end else begin
      case (state)
        S_IDLE: if (in_ch.valid) begin
          pos <= 6'd0;
          raw <= {w.payload_high, w.payload_low};
          neg <= sneg;
          scale <= is_dec ? w.decimal_scale : 8'd0;
          if (is_num || is_dec) begin
            if (w.byte_count < {3'd0, width} + {7'd0, is_dec}) begin
              err_code <= ST_TRUNC; state <= S_ERR;
            end else if (is_dec && w.decimal_scale > 8'(MAX_SCALE)) begin
              err_code <= ST_SCALE; state <= S_ERR;
            end else begin
              kind <= K_NUM; state <= S_CONV;
            end
          end else begin
            kind <= K_TXT; state <= S_EMIT;
            txt <= {"null", 8'h0}; total <= 6'd4;
            case (w.type_id)
              6'd1: txt <= {"true", 8'h0};
              6'd2: begin txt <= "false"; total <= 6'd5; end
              6'd7: begin
                err_code <= (w.byte_count < 8'd8) ? ST_TRUNC : ST_UNSUP; state <= S_ERR;
              end
              6'd14, 6'd15, 6'd16: begin
                err_code <= (w.byte_count < 8'd4) ? ST_TRUNC : ST_UNSUP; state <= S_ERR;
              end
              6'd20: if (w.byte_count < 8'd16) begin
                err_code <= ST_TRUNC; state <= S_ERR;
              end else begin
                kind <= K_UUID; total <= 6'd38;
              end
              default: ;
            endcase
          end
        end
        S_CONV: if (done) begin
          ndig <= nd_c; total <= ntot; state <= S_EMIT;
        end
        S_EMIT: if (out_ch.ready) begin
          pos <= pos + 6'd1;
          if (pos == total - 6'd1) state <= S_IDLE;
        end
        S_ERR: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    out_ch.valid = (state == S_EMIT) || (state == S_ERR);
    if (state == S_ERR) begin
      out_ch.data = '{text_char: 8'd0, last_char: 1'b1, status: err_code};
    end else begin
      out_ch.data = '{text_char: cur_c, last_char: (pos == total - 6'd1), status: ST_OK};
    end
  end

`ifndef SYNTHESIS
  a_noready_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV) |-> !in_ch.ready) else $error("ready while converting");
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.data.status != ST_OK) |-> out_ch.data.last_char)
    else $error("error word not last");
  a_start_conv: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == S_CONV)) else $error("start without conversion");
`endif
endmodule
`default_nettype wire
